/* design/absf_pkg.sv */
// ----------------------------------------------------------------------------
// absf_pkg
// Shared types and constants for the ALU with barrel shifter and NZCV flags.
// ----------------------------------------------------------------------------
package absf_pkg;

    localparam int unsigned DataW   = 32;
    localparam int unsigned OpW     = 4;
    localparam int unsigned ImmW    = 12;
    localparam int unsigned AmtW    = 8;
    localparam int unsigned ShW     = 5;   // log2 of the data width

    localparam logic [DataW-1:0] SignBit = 32'h8000_0000;
    localparam logic [DataW-1:0] AllOnes = 32'hFFFF_FFFF;

    // register shift count that equals the word width
    localparam logic [AmtW-1:0] AmtFull = 8'd32;

    typedef enum logic [OpW-1:0] {
        OP_AND = 4'd0,
        OP_EOR = 4'd1,
        OP_SUB = 4'd2,
        OP_RSB = 4'd3,
        OP_ADD = 4'd4,
        OP_ADC = 4'd5,
        OP_SBC = 4'd6,
        OP_RSC = 4'd7,
        OP_TST = 4'd8,
        OP_TEQ = 4'd9,
        OP_CMP = 4'd10,
        OP_CMN = 4'd11,
        OP_ORR = 4'd12,
        OP_MOV = 4'd13,
        OP_BIC = 4'd14,
        OP_MVN = 4'd15
    } t_alu_op;

    typedef enum logic [1:0] {
        SH_LSL = 2'd0,
        SH_LSR = 2'd1,
        SH_ASR = 2'd2,
        SH_ROR = 2'd3
    } t_shift;

endpackage

/* design/alu_barrel_shifter_flags.sv */
// ----------------------------------------------------------------------------
// alu_barrel_shifter_flags
// One 32-bit data-processing operation: operand-2 shifter, adder/logic unit
// and N, Z, C, V flag generation.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive the operation fields with start high; the word is
//   taken at the rising edge where start is high and busy is low. busy only
//   rises while i_rst_n is asserted, so a new word may be issued every cycle.
//   Result channel: o_valid marks one cycle in which the result word and its
//   strobes/flags stand on the o_ ports. There is no backpressure; the
//   receiver must take it in that cycle.
//   Each word passes through the input register, then the result register.
//   Throughput: one word per cycle; the shifter and the 32-bit adder both
//   sit in the single stage between the two registers, and that path sets
//   the clock.
//   Reset (synchronous, active low) drops both valid bits, so words in flight
//   are discarded and no result appears until a new word is issued.
//   Flags are always computed; o_update_flags / o_restore_status tell the
//   core whether to commit them.
// ----------------------------------------------------------------------------
module alu_barrel_shifter_flags
    import absf_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  logic [OpW-1:0]   i_operation,
    input  logic [DataW-1:0] i_first_operand,
    input  logic [DataW-1:0] i_register_operand,
    input  logic [ImmW-1:0]  i_rotated_immediate,
    input  logic             i_use_immediate,
    input  logic [1:0]       i_shift_type,
    input  logic [AmtW-1:0]  i_shift_amount,
    input  logic             i_shift_by_register,
    input  logic             i_set_flags,
    input  logic             i_dest_is_pc,
    input  logic             i_carry_in,
    input  logic             i_overflow_in,
    output logic             o_valid,
    output logic [DataW-1:0] o_result_value,
    output logic             o_write_result,
    output logic             o_update_flags,
    output logic             o_restore_status,
    output logic             o_flush_pipeline,
    output logic             o_negative_out,
    output logic             o_zero_out,
    output logic             o_carry_out,
    output logic             o_overflow_out
);

    // ------------------------------------------------------------------
    // Input register
    // ------------------------------------------------------------------
    logic             r_vld_in;
    t_alu_op          r_op;
    logic [DataW-1:0] r_a;
    logic [DataW-1:0] r_rm;
    logic [ImmW-1:0]  r_imm;
    logic             r_use_imm;
    t_shift           r_stype;
    logic [AmtW-1:0]  r_amt;
    logic             r_by_reg;
    logic             r_sflag;
    logic             r_to_pc;
    logic             r_cin;
    logic             r_vin;

    logic accept;

    // held off only while reset is applied
    assign busy   = ~i_rst_n;
    assign accept = start & ~busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_in <= 1'b0;
        end else begin
            r_vld_in <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op      <= t_alu_op'(i_operation);
            r_a       <= i_first_operand;
            r_rm      <= i_register_operand;
            r_imm     <= i_rotated_immediate;
            r_use_imm <= i_use_immediate;
            r_stype   <= t_shift'(i_shift_type);
            r_amt     <= i_shift_amount;
            r_by_reg  <= i_shift_by_register;
            r_sflag   <= i_set_flags;
            r_to_pc   <= i_dest_is_pc;
            r_cin     <= i_carry_in;
            r_vin     <= i_overflow_in;
        end
    end

    // ------------------------------------------------------------------
    // Operand-2 shifter
    // ------------------------------------------------------------------
    logic [ShW-1:0]     sh;        // effective 5-bit distance
    logic [DataW:0]     lsl_w;     // {carry, value}
    logic [DataW:0]     lsr_w;     // {value, carry}
    logic [DataW:0]     asr_w;
    logic [2*DataW-1:0] ror_w;
    logic [DataW-1:0]   ror_v;
    logic [DataW-1:0]   imm_v;
    logic [3:0]         imm_rot;
    logic               sign;
    logic               amt_zero;
    logic               amt_over;  // register count above the word width
    logic               amt_full;  // register count exactly the word width
    logic [DataW-1:0]   op2;
    logic               sh_c;

    assign sh       = r_amt[ShW-1:0];
    assign sign     = r_rm[DataW-1];
    assign lsl_w    = {1'b0, r_rm} << sh;
    assign lsr_w    = {r_rm, 1'b0} >> sh;
    assign asr_w    = $signed({r_rm, 1'b0}) >>> sh;
    assign ror_w    = {r_rm, r_rm} >> sh;
    assign ror_v    = ror_w[DataW-1:0];
    assign amt_full = (r_amt == AmtFull);
    assign amt_over = (r_amt > AmtFull);
    assign amt_zero = r_by_reg ? (r_amt == '0) : (sh == '0);

    // immediate: byte rotated right by twice the 4-bit count
    assign imm_rot = r_imm[ImmW-1 -: 4];
    always_comb begin
        logic [2*DataW-1:0] w;
        logic [ShW-1:0]     d;
        d     = {imm_rot, 1'b0};
        w     = {DataW'(r_imm[7:0]), DataW'(r_imm[7:0])} >> d;
        imm_v = w[DataW-1:0];
    end

    always_comb begin
        op2  = r_rm;
        sh_c = r_cin;
        if (r_use_imm) begin
            op2  = imm_v;
            sh_c = (imm_rot == '0) ? r_cin : imm_v[DataW-1];
        end else if (amt_zero) begin
            if (!r_by_reg) begin
                // immediate count of zero encodes the special forms
                unique case (r_stype)
                    SH_LSL: begin
                        op2  = r_rm;
                        sh_c = r_cin;
                    end
                    SH_LSR: begin
                        op2  = '0;
                        sh_c = sign;
                    end
                    SH_ASR: begin
                        op2  = {DataW{sign}};
                        sh_c = sign;
                    end
                    SH_ROR: begin  // RRX
                        op2  = {r_cin, r_rm[DataW-1:1]};
                        sh_c = r_rm[0];
                    end
                    default: begin
                        op2  = r_rm;
                        sh_c = r_cin;
                    end
                endcase
            end
        end else begin
            unique case (r_stype)
                SH_LSL: begin
                    if (r_by_reg && amt_over) begin
                        op2  = '0;
                        sh_c = 1'b0;
                    end else if (r_by_reg && amt_full) begin
                        op2  = '0;
                        sh_c = r_rm[0];
                    end else begin
                        op2  = lsl_w[DataW-1:0];
                        sh_c = lsl_w[DataW];
                    end
                end
                SH_LSR: begin
                    if (r_by_reg && amt_over) begin
                        op2  = '0;
                        sh_c = 1'b0;
                    end else if (r_by_reg && amt_full) begin
                        op2  = '0;
                        sh_c = sign;
                    end else begin
                        op2  = lsr_w[DataW:1];
                        sh_c = lsr_w[0];
                    end
                end
                SH_ASR: begin
                    if (r_by_reg && (amt_over || amt_full)) begin
                        op2  = {DataW{sign}};
                        sh_c = sign;
                    end else begin
                        op2  = asr_w[DataW:1];
                        sh_c = asr_w[0];
                    end
                end
                SH_ROR: begin
                    // multiple of 32 leaves value, carry is bit 31 either way
                    op2  = ror_v;
                    sh_c = ror_v[DataW-1];
                end
                default: begin
                    op2  = r_rm;
                    sh_c = r_cin;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Adder and logic unit
    // ------------------------------------------------------------------
    logic [DataW-1:0] add_x;
    logic [DataW-1:0] add_y;
    logic             add_ci;
    logic [DataW:0]   sum;
    logic             is_arith;
    logic             wr;
    logic [DataW-1:0] res;

    always_comb begin
        add_x    = r_a;
        add_y    = op2;
        add_ci   = 1'b0;
        is_arith = 1'b1;
        wr       = 1'b1;
        unique case (r_op)
            OP_SUB: begin
                add_y  = ~op2;
                add_ci = 1'b1;
            end
            OP_RSB: begin
                add_x  = op2;
                add_y  = ~r_a;
                add_ci = 1'b1;
            end
            OP_ADD: add_ci = 1'b0;
            OP_ADC: add_ci = r_cin;
            OP_SBC: begin
                add_y  = ~op2;
                add_ci = r_cin;
            end
            OP_RSC: begin
                add_x  = op2;
                add_y  = ~r_a;
                add_ci = r_cin;
            end
            OP_CMP: begin
                add_y  = ~op2;
                add_ci = 1'b1;
                wr     = 1'b0;
            end
            OP_CMN: wr = 1'b0;
            OP_TST, OP_TEQ: begin
                is_arith = 1'b0;
                wr       = 1'b0;
            end
            default: is_arith = 1'b0;
        endcase
    end

    assign sum = {1'b0, add_x} + {1'b0, add_y} + {{DataW{1'b0}}, add_ci};

    always_comb begin
        unique case (r_op)
            OP_AND, OP_TST: res = r_a & op2;
            OP_EOR, OP_TEQ: res = r_a ^ op2;
            OP_ORR:         res = r_a | op2;
            OP_MOV:         res = op2;
            OP_BIC:         res = r_a & ~op2;
            OP_MVN:         res = ~op2;
            default:        res = sum[DataW-1:0];
        endcase
    end

    logic c_next;
    logic v_next;
    logic add_v;

    assign add_v  = |((~(add_x ^ add_y)) & (add_x ^ sum[DataW-1:0]) & SignBit);
    assign c_next = is_arith ? sum[DataW] : sh_c;
    assign v_next = is_arith ? add_v : r_vin;

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r_vld_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_vld_in) begin
            o_result_value   <= res;
            o_write_result   <= wr;
            o_update_flags   <= r_sflag & ~r_to_pc;
            o_restore_status <= r_sflag & r_to_pc;
            o_flush_pipeline <= wr & r_to_pc;
            o_negative_out   <= res[DataW-1];
            o_zero_out       <= (res == '0);
            o_carry_out      <= c_next;
            o_overflow_out   <= v_next;
        end
    end

endmodule

/* design/absf_checker.sv */
// ----------------------------------------------------------------------------
// absf_checker
// Port-level checks for alu_barrel_shifter_flags, bound to the top level.
// ----------------------------------------------------------------------------
module absf_checker
    import absf_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             start,
    input logic             busy,
    input logic [OpW-1:0]   i_operation,
    input logic             o_valid,
    input logic [DataW-1:0] o_result_value,
    input logic             o_write_result,
    input logic             o_update_flags,
    input logic             o_restore_status,
    input logic             o_flush_pipeline,
    input logic             o_negative_out,
    input logic             o_zero_out
);

    // every accepted word yields exactly one result, after the input and result registers
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid == $past(start && !busy, 2))
        else $error("result strobe does not follow accepted word");

    // test and compare opcodes never write back
    a_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_write_result == !($past(i_operation, 2) == OP_TST ||
                                        $past(i_operation, 2) == OP_TEQ ||
                                        $past(i_operation, 2) == OP_CMP ||
                                        $past(i_operation, 2) == OP_CMN))
        else $error("write strobe wrong for opcode");

    a_nz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_zero_out == (o_result_value == '0)) &&
                    (o_negative_out == o_result_value[DataW-1]))
        else $error("N/Z flags disagree with result");

    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_update_flags && o_restore_status))
        else $error("flag update and status restore both set");

    a_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_flush_pipeline |-> o_write_result)
        else $error("flush without write-back");

endmodule

bind alu_barrel_shifter_flags absf_checker u_absf_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .start            (start),
    .busy             (busy),
    .i_operation      (i_operation),
    .o_valid          (o_valid),
    .o_result_value   (o_result_value),
    .o_write_result   (o_write_result),
    .o_update_flags   (o_update_flags),
    .o_restore_status (o_restore_status),
    .o_flush_pipeline (o_flush_pipeline),
    .o_negative_out   (o_negative_out),
    .o_zero_out       (o_zero_out)
);
